// File: hdl/dilepton_fiducial_cut_selector_assert.svh
// Assertion macros for the dilepton fiducial cut selector.
`ifndef DILEPTON_FIDUCIAL_CUT_SELECTOR_ASSERT_SVH
`define DILEPTON_FIDUCIAL_CUT_SELECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define DFCS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfcs assertion failed");
`define DFCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfcs assertion failed");
`else
`define DFCS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DFCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/dfcs_pkg.sv
package dfcs_pkg;

  localparam int MOMENTUM_BITS_DEF = 20;
  localparam int FRACTION_BITS_DEF = 6;

  localparam int CFG_W = 19;
  localparam int RAP_W = 17;
  localparam int CFG_SQ_W = 2 * CFG_W;
  localparam int REG_IDX_W = 3;

  localparam logic [2:0] CS_NONE     = 3'd0;
  localparam logic [2:0] CS_GENERAL  = 3'd1;
  localparam logic [2:0] CS_PRESET_A = 3'd2;
  localparam logic [2:0] CS_PRESET_B = 3'd3;
  localparam logic [2:0] CS_PRESET_C = 3'd4;
  localparam logic [2:0] CS_PRESET_D = 3'd5;

  localparam logic [1:0] PROC_NONE     = 2'd0;
  localparam logic [1:0] PROC_W_SECOND = 2'd1;
  localparam logic [1:0] PROC_W_FIRST  = 2'd2;
  localparam logic [1:0] PROC_Z        = 2'd3;

  localparam logic [2:0] REG_CUT_SET        = 3'd0;
  localparam logic [2:0] REG_PROCESS        = 3'd1;
  localparam logic [2:0] REG_LEPTON_PT_MIN  = 3'd2;
  localparam logic [2:0] REG_LEPTON_RAP     = 3'd3;
  localparam logic [2:0] REG_MT_MIN         = 3'd4;
  localparam logic [2:0] REG_ETMISS_MIN     = 3'd5;
  localparam logic [2:0] REG_LEAD_PT_MIN    = 3'd6;
  localparam logic [2:0] REG_SUBLEAD_PT_MIN = 3'd7;

  localparam logic [2:0] REASON_NONE = 3'd0;
  localparam logic [2:0] REASON_PT   = 3'd1;
  localparam logic [2:0] REASON_ETA  = 3'd2;
  localparam logic [2:0] REASON_MASS = 3'd3;
  localparam logic [2:0] REASON_MT   = 3'd4;
  localparam logic [2:0] REASON_MET  = 3'd5;
  localparam logic [2:0] REASON_LEAD = 3'd6;

  localparam logic [RAP_W-1:0] RAP_RESET = 17'd65536;

  // squared tanh of the crack gap edges, Q0.32
  localparam logic [31:0] GAP_LO2 = 32'd2752261444;
  localparam logic [31:0] GAP_HI2 = 32'd3518862400;

  typedef struct packed {
    logic [2:0]          cut_set;
    logic [1:0]          process;
    logic [CFG_W-1:0]    lepton_pt_min;
    logic [RAP_W-1:0]    lepton_rap_tanh;
    logic [CFG_W-1:0]    mt_min;
    logic [CFG_W-1:0]    etmiss_min;
    logic [CFG_SQ_W-1:0] pt_min2;
    logic [CFG_SQ_W-1:0] mt_min2;
    logic [CFG_SQ_W-1:0] etmiss_min2;
    logic [CFG_SQ_W-1:0] lead_pt_min2;
    logic [CFG_SQ_W-1:0] sublead_pt_min2;
  } cfg_t;

  typedef struct packed {
    logic gen_pt;
    logic gen_rap;
    logic gen_etm;
    logic gen_lead;
    logic pre_pt_a;
    logic pre_pt_b;
    logic mass_out;
    logic mt_skip;
    logic eta_a;
    logic eta_b;
  } flag_t;

  function automatic int maxi(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic is_preset(input logic [2:0] cs);
    return (cs == CS_PRESET_A) || (cs == CS_PRESET_B) || (cs == CS_PRESET_C) ||
           (cs == CS_PRESET_D);
  endfunction

  // squared limits in whole GeV
  function automatic logic [9:0] preset_pt2(input logic [2:0] cs);
    logic [9:0] v;
    unique case (cs)
      CS_PRESET_A: v = 10'd625;
      CS_PRESET_B: v = 10'd400;
      CS_PRESET_C: v = 10'd400;
      CS_PRESET_D: v = 10'd625;
      default:     v = 10'd0;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] preset_wpt2(input logic [2:0] cs);
    logic [9:0] v;
    unique case (cs)
      CS_PRESET_A: v = 10'd625;
      CS_PRESET_B: v = 10'd400;
      CS_PRESET_C: v = 10'd625;
      default:     v = 10'd0;
    endcase
    return v;
  endfunction

  function automatic logic [10:0] preset_wmt2(input logic [2:0] cs);
    return (cs == CS_PRESET_C) ? 11'd1600 : 11'd0;
  endfunction

  function automatic logic [13:0] preset_mlo2(input logic [2:0] cs);
    logic [13:0] v;
    unique case (cs)
      CS_PRESET_A: v = 14'd5625;
      CS_PRESET_B: v = 14'd4356;
      CS_PRESET_C: v = 14'd4356;
      CS_PRESET_D: v = 14'd3600;
      default:     v = 14'd0;
    endcase
    return v;
  endfunction

  function automatic logic [13:0] preset_mhi2(input logic [2:0] cs);
    logic [13:0] v;
    unique case (cs)
      CS_PRESET_A: v = 14'd11025;
      CS_PRESET_B: v = 14'd13456;
      CS_PRESET_C: v = 14'd13456;
      CS_PRESET_D: v = 14'd14400;
      default:     v = 14'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] preset_eta2(input logic [2:0] cs);
    logic [31:0] v;
    unique case (cs)
      CS_PRESET_A: v = 32'd4180786281;
      CS_PRESET_B: v = 32'd2491207744;
      CS_PRESET_C: v = 32'd4155865156;
      CS_PRESET_D: v = 32'd4044960000;
      default:     v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/dilepton_fiducial_cut_selector.sv
// Dilepton fiducial selection: each item carries two lepton four-momenta and
// yields one accept flag with a reject reason. The datapath is a four-stage
// pipeline (squares, constant products and threshold compares, wide
// partial products, final reduction and decision in the output register),
// so one item is taken per clock while the output is not stalled, and each
// result passes the kin, prod, sq and judge registers. Stall propagates back
// only through full stages. Write configuration only while no item is in
// flight; squared thresholds settle in the cycle after a register write.
`include "dilepton_fiducial_cut_selector_assert.svh"

module dilepton_fiducial_cut_selector #(
  parameter int MOMENTUM_BITS = dfcs_pkg::MOMENTUM_BITS_DEF,
  parameter int FRACTION_BITS = dfcs_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [dfcs_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [dfcs_pkg::CFG_W-1:0]       wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [MOMENTUM_BITS-1:0]  first_px,
  input  logic signed [MOMENTUM_BITS-1:0]  first_py,
  input  logic signed [MOMENTUM_BITS-1:0]  first_pz,
  input  logic [MOMENTUM_BITS-2:0]         first_energy,
  input  logic signed [MOMENTUM_BITS-1:0]  second_px,
  input  logic signed [MOMENTUM_BITS-1:0]  second_py,
  input  logic signed [MOMENTUM_BITS-1:0]  second_pz,
  input  logic [MOMENTUM_BITS-2:0]         second_energy,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             accept,
  output logic [2:0]                       reject_reason
);
  import dfcs_pkg::*;

  localparam int M  = MOMENTUM_BITS;
  localparam int RW = maxi(CFG_SQ_W, 2 * M + 1) + 1;
  localparam int RH = (RW + 1) / 2;

  logic [2:0]       cut_set;
  logic [1:0]       process;
  logic [CFG_W-1:0] lepton_pt_min, mt_min, etmiss_min, lead_pt_min, sublead_pt_min;
  logic [RAP_W-1:0] lepton_rap_tanh;
  logic [CFG_SQ_W-1:0] pt_min2, mt_min2, etmiss_min2, lead_pt_min2, sublead_pt_min2;
  cfg_t             cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_set         <= CS_NONE;
      process         <= PROC_Z;
      lepton_pt_min   <= '0;
      lepton_rap_tanh <= RAP_RESET;
      mt_min          <= '0;
      etmiss_min      <= '0;
      lead_pt_min     <= '0;
      sublead_pt_min  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CUT_SET:        cut_set         <= wr_data[2:0];
        REG_PROCESS:        process         <= wr_data[1:0];
        REG_LEPTON_PT_MIN:  lepton_pt_min   <= wr_data;
        REG_LEPTON_RAP:     lepton_rap_tanh <= wr_data[RAP_W-1:0];
        REG_MT_MIN:         mt_min          <= wr_data;
        REG_ETMISS_MIN:     etmiss_min      <= wr_data;
        REG_LEAD_PT_MIN:    lead_pt_min     <= wr_data;
        REG_SUBLEAD_PT_MIN: sublead_pt_min  <= wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_min2         <= '0;
      mt_min2         <= '0;
      etmiss_min2     <= '0;
      lead_pt_min2    <= '0;
      sublead_pt_min2 <= '0;
    end else begin
      pt_min2         <= CFG_SQ_W'(lepton_pt_min) * CFG_SQ_W'(lepton_pt_min);
      mt_min2         <= CFG_SQ_W'(mt_min) * CFG_SQ_W'(mt_min);
      etmiss_min2     <= CFG_SQ_W'(etmiss_min) * CFG_SQ_W'(etmiss_min);
      lead_pt_min2    <= CFG_SQ_W'(lead_pt_min) * CFG_SQ_W'(lead_pt_min);
      sublead_pt_min2 <= CFG_SQ_W'(sublead_pt_min) * CFG_SQ_W'(sublead_pt_min);
    end
  end

  always_comb begin
    cfg.cut_set         = cut_set;
    cfg.process         = process;
    cfg.lepton_pt_min   = lepton_pt_min;
    cfg.lepton_rap_tanh = lepton_rap_tanh;
    cfg.mt_min          = mt_min;
    cfg.etmiss_min      = etmiss_min;
    cfg.pt_min2         = pt_min2;
    cfg.mt_min2         = mt_min2;
    cfg.etmiss_min2     = etmiss_min2;
    cfg.lead_pt_min2    = lead_pt_min2;
    cfg.sublead_pt_min2 = sublead_pt_min2;
  end

  logic             kin_ready, kin_valid, prod_ready, prod_valid;
  logic             sq_ready, sq_valid, judge_ready;
  logic [2*M-1:0]   pt2_a, pt2_b, p2_a, p2_b, e2, pos, neg;
  logic [2*M-2:0]   pz2_a, pz2_b, pz2_a_q, pz2_b_q;
  logic [M-1:0]     pzm_a, pzm_b;
  logic [M-2:0]     e_a, e_b;
  logic [2*M+1:0]   ps2;
  logic [5:0][M+31:0] part_lo, part_hi;
  logic [RW-1:0]    rhs;
  logic [2*M-1:0]   pt2_a_q, pt2_b_q;
  flag_t            prod_flags, sq_flags;
  logic [2*RH-1:0]  rr_hh, rr_hl, rr_ll;
  logic [2*M-1:0]   pp_hh, pp_hl, pp_lh, pp_ll;

  assign in_stall = !kin_ready;

  dfcs_kin #(.MOMENTUM_BITS(MOMENTUM_BITS)) u_kin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (kin_ready),
    .a_px      (first_px),
    .a_py      (first_py),
    .a_pz      (first_pz),
    .a_e       (first_energy),
    .b_px      (second_px),
    .b_py      (second_py),
    .b_pz      (second_pz),
    .b_e       (second_energy),
    .out_valid (kin_valid),
    .out_ready (prod_ready),
    .pt2_a     (pt2_a),
    .pt2_b     (pt2_b),
    .p2_a      (p2_a),
    .p2_b      (p2_b),
    .pz2_a     (pz2_a),
    .pz2_b     (pz2_b),
    .pzm_a     (pzm_a),
    .pzm_b     (pzm_b),
    .e_a       (e_a),
    .e_b       (e_b),
    .e2        (e2),
    .ps2       (ps2),
    .pos       (pos),
    .neg       (neg)
  );

  dfcs_prod #(
    .MOMENTUM_BITS (MOMENTUM_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .RW            (RW)
  ) u_prod (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (kin_valid),
    .in_ready  (prod_ready),
    .pt2_a     (pt2_a),
    .pt2_b     (pt2_b),
    .p2_a      (p2_a),
    .p2_b      (p2_b),
    .pz2_a     (pz2_a),
    .pz2_b     (pz2_b),
    .pzm_a     (pzm_a),
    .pzm_b     (pzm_b),
    .e_a       (e_a),
    .e_b       (e_b),
    .e2        (e2),
    .ps2       (ps2),
    .pos       (pos),
    .neg       (neg),
    .out_valid (prod_valid),
    .out_ready (sq_ready),
    .part_lo   (part_lo),
    .part_hi   (part_hi),
    .pz2_a_q   (pz2_a_q),
    .pz2_b_q   (pz2_b_q),
    .rhs       (rhs),
    .pt2_a_q   (pt2_a_q),
    .pt2_b_q   (pt2_b_q),
    .flags     (prod_flags)
  );

  dfcs_sq #(
    .MOMENTUM_BITS (MOMENTUM_BITS),
    .RW            (RW),
    .RH            (RH)
  ) u_sq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (prod_valid),
    .in_ready  (sq_ready),
    .part_lo   (part_lo),
    .part_hi   (part_hi),
    .pz2_a     (pz2_a_q),
    .pz2_b     (pz2_b_q),
    .rhs       (rhs),
    .pt2_a     (pt2_a_q),
    .pt2_b     (pt2_b_q),
    .flags_in  (prod_flags),
    .out_valid (sq_valid),
    .out_ready (judge_ready),
    .rr_hh     (rr_hh),
    .rr_hl     (rr_hl),
    .rr_ll     (rr_ll),
    .pp_hh     (pp_hh),
    .pp_hl     (pp_hl),
    .pp_lh     (pp_lh),
    .pp_ll     (pp_ll),
    .flags     (sq_flags)
  );

  dfcs_judge #(
    .MOMENTUM_BITS (MOMENTUM_BITS),
    .RW            (RW),
    .RH            (RH)
  ) u_judge (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (sq_valid),
    .in_ready      (judge_ready),
    .rr_hh         (rr_hh),
    .rr_hl         (rr_hl),
    .rr_ll         (rr_ll),
    .pp_hh         (pp_hh),
    .pp_hl         (pp_hl),
    .pp_lh         (pp_lh),
    .pp_ll         (pp_ll),
    .flags         (sq_flags),
    .out_valid     (out_valid),
    .out_ready     (!out_stall),
    .accept        (accept),
    .reject_reason (reject_reason)
  );

  `DFCS_ASSERT_IMPL(a_stall_only_when_full, clk, rst, in_stall, out_valid && out_stall && kin_valid && prod_valid && sq_valid)
  `DFCS_ASSERT_NEXT(a_accepted_item_enters, clk, rst, in_valid && !in_stall, kin_valid)
  `DFCS_ASSERT_IMPL(a_accept_has_no_reason, clk, rst, out_valid, accept == (reject_reason == REASON_NONE))

endmodule

// File: hdl/dfcs_kin.sv
module dfcs_kin #(
  parameter int MOMENTUM_BITS = dfcs_pkg::MOMENTUM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [MOMENTUM_BITS-1:0] a_px,
  input  logic signed [MOMENTUM_BITS-1:0] a_py,
  input  logic signed [MOMENTUM_BITS-1:0] a_pz,
  input  logic [MOMENTUM_BITS-2:0]       a_e,
  input  logic signed [MOMENTUM_BITS-1:0] b_px,
  input  logic signed [MOMENTUM_BITS-1:0] b_py,
  input  logic signed [MOMENTUM_BITS-1:0] b_pz,
  input  logic [MOMENTUM_BITS-2:0]       b_e,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2*MOMENTUM_BITS-1:0]     pt2_a,
  output logic [2*MOMENTUM_BITS-1:0]     pt2_b,
  output logic [2*MOMENTUM_BITS-1:0]     p2_a,
  output logic [2*MOMENTUM_BITS-1:0]     p2_b,
  output logic [2*MOMENTUM_BITS-2:0]     pz2_a,
  output logic [2*MOMENTUM_BITS-2:0]     pz2_b,
  output logic [MOMENTUM_BITS-1:0]       pzm_a,
  output logic [MOMENTUM_BITS-1:0]       pzm_b,
  output logic [MOMENTUM_BITS-2:0]       e_a,
  output logic [MOMENTUM_BITS-2:0]       e_b,
  output logic [2*MOMENTUM_BITS-1:0]     e2,
  output logic [2*MOMENTUM_BITS+1:0]     ps2,
  output logic [2*MOMENTUM_BITS-1:0]     pos,
  output logic [2*MOMENTUM_BITS-1:0]     neg
);
  import dfcs_pkg::*;

  localparam int M = MOMENTUM_BITS;

  function automatic logic [M-1:0] mag(input logic signed [M-1:0] x);
    return x[M-1] ? M'(~x + 1'b1) : M'(x);
  endfunction

  function automatic logic [M:0] mag1(input logic signed [M:0] x);
    return x[M] ? (M+1)'(~x + 1'b1) : (M+1)'(x);
  endfunction

  logic [M-1:0]       mx_a, my_a, mz_a, mx_b, my_b, mz_b;
  logic [2*M-1:0]     sx_a, sy_a, sx_b, sy_b, cx, cy;
  logic [2*M-2:0]     sz_a, sz_b;
  logic [2*M-1:0]     pt2_a_next, pt2_b_next;
  logic signed [M:0]  tx, ty, tz;
  logic [M:0]         mtx, mty, mtz;
  logic [2*M+1:0]     ps2_next;
  logic [M-1:0]       es;
  logic [2*M-1:0]     pos_next, neg_next;

  always_comb begin
    mx_a = mag(a_px);
    my_a = mag(a_py);
    mz_a = mag(a_pz);
    mx_b = mag(b_px);
    my_b = mag(b_py);
    mz_b = mag(b_pz);
    sx_a = (2*M)'(mx_a) * (2*M)'(mx_a);
    sy_a = (2*M)'(my_a) * (2*M)'(my_a);
    sz_a = (2*M-1)'((2*M)'(mz_a) * (2*M)'(mz_a));
    sx_b = (2*M)'(mx_b) * (2*M)'(mx_b);
    sy_b = (2*M)'(my_b) * (2*M)'(my_b);
    sz_b = (2*M-1)'((2*M)'(mz_b) * (2*M)'(mz_b));
    pt2_a_next = sx_a + sy_a;
    pt2_b_next = sx_b + sy_b;
    tx = (M+1)'(a_px) + (M+1)'(b_px);
    ty = (M+1)'(a_py) + (M+1)'(b_py);
    tz = (M+1)'(a_pz) + (M+1)'(b_pz);
    mtx = mag1(tx);
    mty = mag1(ty);
    mtz = mag1(tz);
    ps2_next = (2*M+2)'(mtx) * (2*M+2)'(mtx) + (2*M+2)'(mty) * (2*M+2)'(mty) +
               (2*M+2)'(mtz) * (2*M+2)'(mtz);
    es = M'(a_e) + M'(b_e);
    cx = (2*M)'(mx_a) * (2*M)'(mx_b);
    cy = (2*M)'(my_a) * (2*M)'(my_b);
    pos_next = ((a_px[M-1] ^ b_px[M-1]) ? '0 : cx) + ((a_py[M-1] ^ b_py[M-1]) ? '0 : cy);
    neg_next = ((a_px[M-1] ^ b_px[M-1]) ? cx : '0) + ((a_py[M-1] ^ b_py[M-1]) ? cy : '0);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pt2_a <= pt2_a_next;
      pt2_b <= pt2_b_next;
      p2_a  <= pt2_a_next + (2*M)'(sz_a);
      p2_b  <= pt2_b_next + (2*M)'(sz_b);
      pz2_a <= sz_a;
      pz2_b <= sz_b;
      pzm_a <= mz_a;
      pzm_b <= mz_b;
      e_a   <= a_e;
      e_b   <= b_e;
      e2    <= (2*M)'(es) * (2*M)'(es);
      ps2   <= ps2_next;
      pos   <= pos_next;
      neg   <= neg_next;
    end
  end

endmodule

// File: hdl/dfcs_prod.sv
module dfcs_prod #(
  parameter int MOMENTUM_BITS = dfcs_pkg::MOMENTUM_BITS_DEF,
  parameter int FRACTION_BITS = dfcs_pkg::FRACTION_BITS_DEF,
  parameter int RW = dfcs_pkg::maxi(2 * dfcs_pkg::CFG_W, 2 * MOMENTUM_BITS + 1) + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dfcs_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2*MOMENTUM_BITS-1:0]           pt2_a,
  input  logic [2*MOMENTUM_BITS-1:0]           pt2_b,
  input  logic [2*MOMENTUM_BITS-1:0]           p2_a,
  input  logic [2*MOMENTUM_BITS-1:0]           p2_b,
  input  logic [2*MOMENTUM_BITS-2:0]           pz2_a,
  input  logic [2*MOMENTUM_BITS-2:0]           pz2_b,
  input  logic [MOMENTUM_BITS-1:0]             pzm_a,
  input  logic [MOMENTUM_BITS-1:0]             pzm_b,
  input  logic [MOMENTUM_BITS-2:0]             e_a,
  input  logic [MOMENTUM_BITS-2:0]             e_b,
  input  logic [2*MOMENTUM_BITS-1:0]           e2,
  input  logic [2*MOMENTUM_BITS+1:0]           ps2,
  input  logic [2*MOMENTUM_BITS-1:0]           pos,
  input  logic [2*MOMENTUM_BITS-1:0]           neg,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [5:0][MOMENTUM_BITS+31:0]       part_lo,
  output logic [5:0][MOMENTUM_BITS+31:0]       part_hi,
  output logic [2*MOMENTUM_BITS-2:0]           pz2_a_q,
  output logic [2*MOMENTUM_BITS-2:0]           pz2_b_q,
  output logic [RW-1:0]                        rhs,
  output logic [2*MOMENTUM_BITS-1:0]           pt2_a_q,
  output logic [2*MOMENTUM_BITS-1:0]           pt2_b_q,
  output dfcs_pkg::flag_t                      flags
);
  import dfcs_pkg::*;

  localparam int M = MOMENTUM_BITS;
  localparam int F = FRACTION_BITS;
  localparam int PCW = maxi(2 * M, CFG_SQ_W);
  localparam int MWD = maxi(2 * M + 2, 2 * (7 + F)) + 1;
  localparam int RPW = M + 16;

  logic [2:0][31:0]       t2;
  logic [5:0][M+31:0]     lo_next, hi_next;
  logic [PCW-1:0]         a2, b2, pp2, wp2;
  logic                   a_lt, b_lt, a_lt_e, b_lt_e, a_lead;
  logic                   hi_lt, lo_lt;
  logic                   rap_a, rap_b;
  logic                   chg_lt, chg_rap, miss_lt;
  logic [MWD-1:0]         e2w, lo2, hi2;
  logic [CFG_SQ_W-1:0]    c2;
  logic [RW-1:0]          s, t;
  flag_t                  flags_next;

  always_comb begin
    t2[0] = preset_eta2(cfg.cut_set);
    t2[1] = GAP_LO2;
    t2[2] = GAP_HI2;
    for (int k = 0; k < 3; k++) begin
      lo_next[k]   = (M+32)'(t2[k]) * (M+32)'(p2_a[M-1:0]);
      hi_next[k]   = (M+32)'(t2[k]) * (M+32)'(p2_a[2*M-1:M]);
      lo_next[k+3] = (M+32)'(t2[k]) * (M+32)'(p2_b[M-1:0]);
      hi_next[k+3] = (M+32)'(t2[k]) * (M+32)'(p2_b[2*M-1:M]);
    end

    a2  = PCW'(pt2_a);
    b2  = PCW'(pt2_b);
    pp2 = PCW'(preset_pt2(cfg.cut_set)) << (2 * F);
    wp2 = PCW'(preset_wpt2(cfg.cut_set)) << (2 * F);
    a_lt   = a2 < PCW'(cfg.pt_min2);
    b_lt   = b2 < PCW'(cfg.pt_min2);
    a_lt_e = a2 < PCW'(cfg.etmiss_min2);
    b_lt_e = b2 < PCW'(cfg.etmiss_min2);
    a_lead = pt2_a > pt2_b;
    hi_lt  = (a_lead ? a2 : b2) < PCW'(cfg.lead_pt_min2);
    lo_lt  = (a_lead ? b2 : a2) < PCW'(cfg.sublead_pt_min2);

    rap_a = {pzm_a, 16'b0} > RPW'(cfg.lepton_rap_tanh) * RPW'(e_a);
    rap_b = {pzm_b, 16'b0} > RPW'(cfg.lepton_rap_tanh) * RPW'(e_b);

    unique case (cfg.process)
      PROC_W_SECOND: begin
        chg_lt  = b_lt;
        chg_rap = rap_b;
        miss_lt = a_lt_e;
      end
      PROC_W_FIRST: begin
        chg_lt  = a_lt;
        chg_rap = rap_a;
        miss_lt = b_lt_e;
      end
      PROC_Z: begin
        chg_lt  = a_lt || b_lt;
        chg_rap = rap_a || rap_b;
        miss_lt = 1'b1;
      end
      PROC_NONE: begin
        chg_lt  = 1'b1;
        chg_rap = 1'b0;
        miss_lt = 1'b1;
      end
    endcase

    e2w = MWD'(e2);
    lo2 = MWD'(ps2) + (MWD'(preset_mlo2(cfg.cut_set)) << (2 * F));
    hi2 = MWD'(ps2) + (MWD'(preset_mhi2(cfg.cut_set)) << (2 * F));

    c2 = (cfg.cut_set == CS_GENERAL) ? cfg.mt_min2 :
         (CFG_SQ_W'(preset_wmt2(cfg.cut_set)) << (2 * F));
    s  = RW'(c2) + (RW'(pos) << 1);
    t  = RW'(neg) << 1;

    flags_next          = '0;
    flags_next.gen_pt   = (cfg.lepton_pt_min != '0) && chg_lt;
    flags_next.gen_rap  = !cfg.lepton_rap_tanh[RAP_W-1] && chg_rap;
    flags_next.gen_etm  = (cfg.etmiss_min != '0) && miss_lt;
    flags_next.gen_lead = hi_lt || lo_lt;
    flags_next.pre_pt_a = a2 < pp2;
    flags_next.pre_pt_b = (cfg.process == PROC_Z) ? (b2 < pp2) : (b2 < wp2);
    flags_next.mass_out = (e2w < lo2) || (e2w > hi2);
    flags_next.mt_skip  = s <= t;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      part_lo <= lo_next;
      part_hi <= hi_next;
      pz2_a_q <= pz2_a;
      pz2_b_q <= pz2_b;
      rhs     <= s - t;
      pt2_a_q <= pt2_a;
      pt2_b_q <= pt2_b;
      flags   <= flags_next;
    end
  end

endmodule

// File: hdl/dfcs_sq.sv
module dfcs_sq #(
  parameter int MOMENTUM_BITS = dfcs_pkg::MOMENTUM_BITS_DEF,
  parameter int RW = dfcs_pkg::maxi(2 * dfcs_pkg::CFG_W, 2 * MOMENTUM_BITS + 1) + 1,
  parameter int RH = (RW + 1) / 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dfcs_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [5:0][MOMENTUM_BITS+31:0] part_lo,
  input  logic [5:0][MOMENTUM_BITS+31:0] part_hi,
  input  logic [2*MOMENTUM_BITS-2:0]     pz2_a,
  input  logic [2*MOMENTUM_BITS-2:0]     pz2_b,
  input  logic [RW-1:0]                  rhs,
  input  logic [2*MOMENTUM_BITS-1:0]     pt2_a,
  input  logic [2*MOMENTUM_BITS-1:0]     pt2_b,
  input  dfcs_pkg::flag_t                flags_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2*RH-1:0]                rr_hh,
  output logic [2*RH-1:0]                rr_hl,
  output logic [2*RH-1:0]                rr_ll,
  output logic [2*MOMENTUM_BITS-1:0]     pp_hh,
  output logic [2*MOMENTUM_BITS-1:0]     pp_hl,
  output logic [2*MOMENTUM_BITS-1:0]     pp_lh,
  output logic [2*MOMENTUM_BITS-1:0]     pp_ll,
  output dfcs_pkg::flag_t                flags
);
  import dfcs_pkg::*;

  localparam int M  = MOMENTUM_BITS;
  localparam int EW = 2 * M + 32;

  logic [5:0][EW-1:0] tp;
  logic [EW-1:0]      la, lb;
  logic               bad_a, bad_b;
  logic [RH-1:0]      rh, rl;
  flag_t              flags_next;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      tp[i] = EW'(part_lo[i]) + (EW'(part_hi[i]) << M);
    end
    la = EW'(pz2_a) << 32;
    lb = EW'(pz2_b) << 32;
    bad_a = (la > tp[0]) ||
            ((cfg.cut_set == CS_PRESET_A) && (la > tp[1]) && (la < tp[2]));
    bad_b = (lb > tp[3]) ||
            ((cfg.cut_set == CS_PRESET_A) && (lb > tp[4]) && (lb < tp[5]));
    flags_next       = flags_in;
    flags_next.eta_a = bad_a;
    flags_next.eta_b = bad_b;
    rh = RH'(rhs >> RH);
    rl = rhs[RH-1:0];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rr_hh <= (2*RH)'(rh) * (2*RH)'(rh);
      rr_hl <= (2*RH)'(rh) * (2*RH)'(rl);
      rr_ll <= (2*RH)'(rl) * (2*RH)'(rl);
      pp_hh <= (2*M)'(pt2_a[2*M-1:M]) * (2*M)'(pt2_b[2*M-1:M]);
      pp_hl <= (2*M)'(pt2_a[2*M-1:M]) * (2*M)'(pt2_b[M-1:0]);
      pp_lh <= (2*M)'(pt2_a[M-1:0]) * (2*M)'(pt2_b[2*M-1:M]);
      pp_ll <= (2*M)'(pt2_a[M-1:0]) * (2*M)'(pt2_b[M-1:0]);
      flags <= flags_next;
    end
  end

endmodule

// File: hdl/dfcs_judge.sv
module dfcs_judge #(
  parameter int MOMENTUM_BITS = dfcs_pkg::MOMENTUM_BITS_DEF,
  parameter int RW = dfcs_pkg::maxi(2 * dfcs_pkg::CFG_W, 2 * MOMENTUM_BITS + 1) + 1,
  parameter int RH = (RW + 1) / 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dfcs_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2*RH-1:0]            rr_hh,
  input  logic [2*RH-1:0]            rr_hl,
  input  logic [2*RH-1:0]            rr_ll,
  input  logic [2*MOMENTUM_BITS-1:0] pp_hh,
  input  logic [2*MOMENTUM_BITS-1:0] pp_hl,
  input  logic [2*MOMENTUM_BITS-1:0] pp_lh,
  input  logic [2*MOMENTUM_BITS-1:0] pp_ll,
  input  dfcs_pkg::flag_t            flags,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       accept,
  output logic [2:0]                 reject_reason
);
  import dfcs_pkg::*;

  localparam int M  = MOMENTUM_BITS;
  localparam int QW = 4 * RH + 2;

  logic [QW-1:0] rhs2, lhs;
  logic          mt_low;
  logic [2:0]    reason;

  always_comb begin
    rhs2 = (QW'(rr_hh) << (2 * RH)) + (QW'(rr_hl) << (RH + 1)) + QW'(rr_ll);
    lhs  = ((QW'(pp_hh) << (2 * M)) + ((QW'(pp_hl) + QW'(pp_lh)) << M) + QW'(pp_ll)) << 2;
    mt_low = !flags.mt_skip && (lhs < rhs2);

    reason = REASON_NONE;
    if (cfg.cut_set == CS_GENERAL) begin
      priority if (flags.gen_pt) begin
        reason = REASON_PT;
      end else if (flags.gen_rap) begin
        reason = REASON_ETA;
      end else if ((cfg.mt_min != '0) && mt_low) begin
        reason = REASON_MT;
      end else if (flags.gen_etm) begin
        reason = REASON_MET;
      end else if (flags.gen_lead) begin
        reason = REASON_LEAD;
      end else begin
        reason = REASON_NONE;
      end
    end else if (is_preset(cfg.cut_set)) begin
      priority if (flags.pre_pt_a) begin
        reason = REASON_PT;
      end else if (flags.eta_a) begin
        reason = REASON_ETA;
      end else if (flags.pre_pt_b) begin
        reason = REASON_PT;
      end else if (cfg.process == PROC_Z) begin
        if (flags.eta_b) begin
          reason = REASON_ETA;
        end else if (flags.mass_out) begin
          reason = REASON_MASS;
        end
      end else if ((cfg.cut_set == CS_PRESET_C) && mt_low) begin
        reason = REASON_MT;
      end else begin
        reason = REASON_NONE;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      accept        <= (reason == REASON_NONE);
      reject_reason <= reason;
    end
  end

endmodule

// File: sim/dfcs_checker.sv
module dfcs_checker
  import dfcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [CFG_W-1:0]  wr_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic signed [19:0] first_px,
  input  logic signed [19:0] first_py,
  input  logic signed [19:0] first_pz,
  input  logic [18:0]       first_energy,
  input  logic signed [19:0] second_px,
  input  logic signed [19:0] second_py,
  input  logic signed [19:0] second_pz,
  input  logic [18:0]       second_energy,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              accept,
  input  logic [2:0]        reject_reason,
  output int                errors,
  output int                pending
);

  typedef logic [127:0] u128;

  typedef struct {
    logic        neg_x;
    logic        neg_y;
    u128         ax, ay, az, e, pt2, p2;
  } lepton_t;

  typedef struct {
    logic       acc;
    logic [2:0] reason;
  } verdict_t;

  // preset tables: pt GeV, eta tanh Q0.16, gap, mass window GeV, W pt, W mt
  localparam int P_PT  [4] = '{25, 20, 20, 25};
  localparam int P_ETA [4] = '{64659, 49912, 64466, 63600};
  localparam int P_GLO [4] = '{52462, 0, 0, 0};
  localparam int P_GHI [4] = '{59320, 0, 0, 0};
  localparam int P_MLO [4] = '{75, 66, 66, 60};
  localparam int P_MHI [4] = '{105, 116, 116, 120};
  localparam int P_WPT [4] = '{25, 20, 25, 0};
  localparam int P_WMT [4] = '{0, 0, 40, 0};

  logic [2:0]       cut_set_q;
  logic [1:0]       process_q;
  logic [CFG_W-1:0] chg_pt_min_q, mt_min_q, met_min_q, lead_min_q, sub_min_q;
  logic [RAP_W-1:0] rap_tanh_q;
  verdict_t         verdict_q[$];

  function automatic u128 absval(input logic signed [19:0] x);
    longint v;
    v = x;
    return (v < 0) ? u128'(-v) : u128'(v);
  endfunction

  function automatic lepton_t make_lepton(input logic signed [19:0] px,
                                          input logic signed [19:0] py,
                                          input logic signed [19:0] pz,
                                          input logic [18:0] e);
    lepton_t l;
    l.neg_x = px[19];
    l.neg_y = py[19];
    l.ax = absval(px);
    l.ay = absval(py);
    l.az = absval(pz);
    l.e = u128'(e);
    l.pt2 = l.ax * l.ax + l.ay * l.ay;
    l.p2 = l.pt2 + l.az * l.az;
    return l;
  endfunction

  function automatic logic pt_short(input u128 pt2, input u128 c);
    return pt2 < c * c;
  endfunction

  function automatic int eta_order(input lepton_t l, input u128 t);
    u128 lhs, rhs;
    lhs = (l.az * l.az) << 32;
    rhs = t * t * l.p2;
    return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
  endfunction

  function automatic logic eta_fails(input lepton_t l, input int k);
    if (eta_order(l, P_ETA[k]) > 0) return 1'b1;
    return P_GHI[k] != 0 && eta_order(l, P_GLO[k]) > 0 && eta_order(l, P_GHI[k]) < 0;
  endfunction

  function automatic logic rap_fails(input lepton_t l, input u128 t);
    return (l.az << 16) > t * l.e;
  endfunction

  function automatic logic mass_out(input lepton_t a, input lepton_t b,
                                    input logic signed [19:0] ax, ay, az,
                                    input logic signed [19:0] bx, by, bz,
                                    input u128 lo, input u128 hi);
    u128 es, sx, sy, sz, e2, p2;
    longint vx, vy, vz;
    es = a.e + b.e;
    vx = longint'(ax) + longint'(bx);
    vy = longint'(ay) + longint'(by);
    vz = longint'(az) + longint'(bz);
    sx = (vx < 0) ? u128'(-vx) : u128'(vx);
    sy = (vy < 0) ? u128'(-vy) : u128'(vy);
    sz = (vz < 0) ? u128'(-vz) : u128'(vz);
    e2 = es * es;
    p2 = sx * sx + sy * sy + sz * sz;
    if (e2 < p2 + lo * lo) return 1'b1;
    return e2 > p2 + hi * hi;
  endfunction

  function automatic logic mt_short(input lepton_t a, input lepton_t b, input u128 c);
    u128 pos, neg, s, t, rhs, lhs;
    pos = 0;
    neg = 0;
    if (a.neg_x != b.neg_x) neg += a.ax * b.ax; else pos += a.ax * b.ax;
    if (a.neg_y != b.neg_y) neg += a.ay * b.ay; else pos += a.ay * b.ay;
    s = c * c + (pos << 1);
    t = neg << 1;
    if (s <= t) return 1'b0;
    rhs = s - t;
    lhs = (a.pt2 * b.pt2) << 2;
    return lhs < rhs * rhs;
  endfunction

  function automatic logic [2:0] select_reason(input logic signed [19:0] ax, ay, az,
                                               input logic [18:0] ae,
                                               input logic signed [19:0] bx, by, bz,
                                               input logic [18:0] be);
    lepton_t a, b, chg, miss, hi_l, lo_l;
    logic    has_chg;
    int      k;
    u128     sc;
    a = make_lepton(ax, ay, az, ae);
    b = make_lepton(bx, by, bz, be);
    sc = 64;
    if (is_preset(cut_set_q)) begin
      k = int'(cut_set_q) - int'(CS_PRESET_A);
      if (pt_short(a.pt2, P_PT[k] * sc)) return REASON_PT;
      if (eta_fails(a, k)) return REASON_ETA;
      if (process_q == PROC_Z) begin
        if (pt_short(b.pt2, P_PT[k] * sc)) return REASON_PT;
        if (eta_fails(b, k)) return REASON_ETA;
        if (mass_out(a, b, ax, ay, az, bx, by, bz, P_MLO[k] * sc, P_MHI[k] * sc))
          return REASON_MASS;
      end else begin
        if (pt_short(b.pt2, P_WPT[k] * sc)) return REASON_PT;
        if (P_WMT[k] != 0 && mt_short(a, b, P_WMT[k] * sc)) return REASON_MT;
      end
      return REASON_NONE;
    end
    if (cut_set_q != CS_GENERAL) return REASON_NONE;
    has_chg = process_q == PROC_W_SECOND || process_q == PROC_W_FIRST;
    chg = (process_q == PROC_W_SECOND) ? b : a;
    miss = (process_q == PROC_W_SECOND) ? a : b;
    if (chg_pt_min_q > 0) begin
      if (process_q == PROC_Z) begin
        if (pt_short(a.pt2, chg_pt_min_q) || pt_short(b.pt2, chg_pt_min_q)) return REASON_PT;
      end else if (pt_short(has_chg ? chg.pt2 : 0, chg_pt_min_q)) begin
        return REASON_PT;
      end
    end
    if (rap_tanh_q < RAP_RESET) begin
      if (process_q == PROC_Z) begin
        if (rap_fails(a, rap_tanh_q) || rap_fails(b, rap_tanh_q)) return REASON_ETA;
      end else if (has_chg && rap_fails(chg, rap_tanh_q)) begin
        return REASON_ETA;
      end
    end
    if (mt_min_q > 0 && mt_short(a, b, mt_min_q)) return REASON_MT;
    if (met_min_q > 0 && pt_short(has_chg ? miss.pt2 : 0, met_min_q)) return REASON_MET;
    hi_l = (a.pt2 > b.pt2) ? a : b;
    lo_l = (a.pt2 > b.pt2) ? b : a;
    if (pt_short(hi_l.pt2, lead_min_q) || pt_short(lo_l.pt2, sub_min_q)) return REASON_LEAD;
    return REASON_NONE;
  endfunction

  always @(posedge clk) begin
    verdict_t v, want;
    if (rst) begin
      cut_set_q <= CS_NONE;
      process_q <= PROC_Z;
      chg_pt_min_q <= '0;
      rap_tanh_q <= RAP_RESET;
      mt_min_q <= '0;
      met_min_q <= '0;
      lead_min_q <= '0;
      sub_min_q <= '0;
      verdict_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_CUT_SET:        cut_set_q <= wr_data[2:0];
          REG_PROCESS:        process_q <= wr_data[1:0];
          REG_LEPTON_PT_MIN:  chg_pt_min_q <= wr_data;
          REG_LEPTON_RAP:     rap_tanh_q <= wr_data[RAP_W-1:0];
          REG_MT_MIN:         mt_min_q <= wr_data;
          REG_ETMISS_MIN:     met_min_q <= wr_data;
          REG_LEAD_PT_MIN:    lead_min_q <= wr_data;
          REG_SUBLEAD_PT_MIN: sub_min_q <= wr_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        v.reason = select_reason(first_px, first_py, first_pz, first_energy,
                                 second_px, second_py, second_pz, second_energy);
        v.acc = v.reason == REASON_NONE;
        verdict_q.push_back(v);
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected item accept=%0d reason=%0d", $time, accept,
                   reject_reason);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (want.acc !== accept || want.reason !== reject_reason) begin
            $display("%0t: expected accept=%0d reason=%0d, got accept=%0d reason=%0d",
                     $time, want.acc, want.reason, accept, reject_reason);
            errors++;
          end
        end
      end
      pending = verdict_q.size();
    end
  end

endmodule

// File: sim/dilepton_fiducial_cut_selector_tb.sv
module dilepton_fiducial_cut_selector_tb;
  import dfcs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int GEV = 64;

  logic              clk;
  logic              rst;
  logic              wr_en;
  logic [2:0]        wr_index;
  logic [CFG_W-1:0]  wr_data;
  logic              in_valid;
  logic              in_stall;
  logic signed [19:0] first_px, first_py, first_pz, second_px, second_py, second_pz;
  logic [18:0]       first_energy, second_energy;
  logic              out_valid;
  logic              out_stall;
  logic              accept;
  logic [2:0]        reject_reason;
  int                errors;
  int                pending;
  int                idle_cycles;
  logic              hold_req;

  dilepton_fiducial_cut_selector u_dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_px(first_px), .first_py(first_py), .first_pz(first_pz),
    .first_energy(first_energy),
    .second_px(second_px), .second_py(second_py), .second_pz(second_pz),
    .second_energy(second_energy),
    .out_valid(out_valid), .out_stall(out_stall),
    .accept(accept), .reject_reason(reject_reason)
  );

  dfcs_checker u_checker (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_px(first_px), .first_py(first_py), .first_pz(first_pz),
    .first_energy(first_energy),
    .second_px(second_px), .second_py(second_py), .second_pz(second_pz),
    .second_energy(second_energy),
    .out_valid(out_valid), .out_stall(out_stall),
    .accept(accept), .reject_reason(reject_reason),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int r, n;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        out_stall <= 1'b1;
        hold_req = 1'b0;
        n = 150;
      end else if (r < 55) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 20);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(negedge clk);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val[CFG_W-1:0];
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic configure(input int unsigned cs, input int unsigned prc,
                           input int unsigned ptmin, input int unsigned rap,
                           input int unsigned mt, input int unsigned met,
                           input int unsigned lead, input int unsigned sub);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    write_reg(REG_CUT_SET, cs);
    write_reg(REG_PROCESS, prc);
    write_reg(REG_LEPTON_PT_MIN, ptmin);
    write_reg(REG_LEPTON_RAP, rap);
    write_reg(REG_MT_MIN, mt);
    write_reg(REG_ETMISS_MIN, met);
    write_reg(REG_LEAD_PT_MIN, lead);
    write_reg(REG_SUBLEAD_PT_MIN, sub);
    repeat (2) @(negedge clk);
  endtask

  // called at a falling edge; returns at a falling edge after the item is taken
  task automatic send_event(input logic signed [19:0] ax, ay, az, input logic [18:0] ae,
                            input logic signed [19:0] bx, by, bz, input logic [18:0] be);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = (r < 65) ? 0 : ((r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    first_px <= ax; first_py <= ay; first_pz <= az; first_energy <= ae;
    second_px <= bx; second_py <= by; second_pz <= bz; second_energy <= be;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [19:0] clip(input real v);
    if (v > 524287.0) return 20'sd524287;
    if (v < -524288.0) return -20'sd524288;
    return 20'(longint'(v));
  endfunction

  function automatic logic [18:0] clip_e(input real v);
    if (v > 524287.0) return 19'd524287;
    if (v < 0.0) return 19'd0;
    return 19'(longint'(v));
  endfunction

  task automatic send_random();
    int    mode;
    real   m, phi, ct, st, pt, pz1, pz2, s, c;
    logic signed [19:0] ax, ay, az, bx, by, bz;
    mode = $urandom_range(0, 99);
    if (mode < 15) begin
      send_event($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom);
    end else if (mode < 60) begin
      // back-to-back pair of a given mass with a small longitudinal boost
      m = ($urandom_range(400, 1500) / 10.0) * GEV;
      phi = $urandom_range(0, 6283) / 1000.0;
      ct = ($urandom_range(0, 2000) - 1000) / 1000.0;
      st = $sqrt(1.0 - ct * ct);
      pz1 = m / 2.0 * ct;
      s = ($urandom_range(0, 200) - 100) * GEV / 10.0;
      ax = clip(m / 2.0 * st * $cos(phi));
      ay = clip(m / 2.0 * st * $sin(phi));
      az = clip(pz1 + s);
      send_event(ax, ay, az, clip_e(m / 2.0 + s * ct), -ax, -ay, clip(-pz1 + s),
                 clip_e(m / 2.0 - s * ct + 0.5));
    end else begin
      pt = $urandom_range(0, 80 * GEV);
      phi = $urandom_range(0, 6283) / 1000.0;
      pz1 = $urandom_range(0, 400 * GEV) - 200.0 * GEV;
      ax = clip(pt * $cos(phi));
      ay = clip(pt * $sin(phi));
      az = clip(pz1);
      c = $sqrt(pt * pt + pz1 * pz1) + $urandom_range(0, 3 * GEV) - GEV;
      pt = $urandom_range(0, 80 * GEV);
      phi = $urandom_range(0, 6283) / 1000.0;
      pz2 = $urandom_range(0, 400 * GEV) - 200.0 * GEV;
      bx = clip(pt * $cos(phi));
      by = clip(pt * $sin(phi));
      bz = clip(pz2);
      m = $sqrt(pt * pt + pz2 * pz2) + $urandom_range(0, 3 * GEV) - GEV;
      send_event(ax, ay, az, clip_e(c), bx, by, bz, clip_e(m));
    end
  endtask

  task automatic send_directed();
    send_event(0, 0, 0, 0, 0, 0, 0, 0);
    send_event(20'sd524287, 20'sd524287, 20'sd524287, 19'd524287,
               20'sd524287, 20'sd524287, 20'sd524287, 19'd524287);
    send_event(-20'sd524288, -20'sd524288, -20'sd524288, 19'd524287,
               -20'sd524288, -20'sd524288, -20'sd524288, 19'd524287);
    send_event(-20'sd524288, 20'sd524287, 0, 0, 20'sd524287, -20'sd524288, 0, 0);
    send_event(30 * GEV, 0, 0, 30 * GEV, -30 * GEV, 0, 0, 30 * GEV);
    send_event(30 * GEV, 0, 40 * GEV, 10 * GEV, 0, 30 * GEV, -50 * GEV, 20 * GEV);
    send_event(30 * GEV, 0, 0, 0, 30 * GEV, 0, 0, 0);
    send_event(0, 0, 50 * GEV, 50 * GEV, 0, 0, -50 * GEV, 50 * GEV);
    send_event(45 * GEV, 0, 0, 45 * GEV, -45 * GEV, 0, 0, 45 * GEV);
    send_event(25 * GEV, 0, 0, 25 * GEV, 0, 25 * GEV, 0, 25 * GEV);
    send_event(25 * GEV - 1, 0, 0, 25 * GEV, 0, -25 * GEV, 0, 25 * GEV);
    send_event(40 * GEV, 0, 41 * GEV, 60 * GEV, -40 * GEV, 0, -41 * GEV, 60 * GEV);
    send_event(30 * GEV, 10 * GEV, 0, 35 * GEV, 20 * GEV, -30 * GEV, 5 * GEV, 40 * GEV);
    send_event(-20'sd1, -20'sd1, -20'sd1, 19'd1, 20'sd1, 20'sd1, 20'sd1, 19'd1);
    send_event(20'sd524287, 0, 0, 19'd0, 0, 0, 20'sd524287, 19'd524287);
    send_event(50 * GEV, 0, 0, 0, 0, 50 * GEV, 0, 0);
  endtask

  task automatic run_phase(input int n, input logic with_hold);
    if (with_hold) hold_req = 1'b1;
    repeat (n) send_random();
    in_valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    hold_req = 1'b0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    in_valid = 1'b0;
    first_px = '0; first_py = '0; first_pz = '0; first_energy = '0;
    second_px = '0; second_py = '0; second_pz = '0; second_energy = '0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_phase(40, 1'b0);
    configure(CS_GENERAL, PROC_Z, 20 * GEV, 63600, 0, 0, 25 * GEV, 15 * GEV);
    send_directed();
    in_valid <= 1'b0;
    run_phase(50, 1'b1);
    configure(CS_GENERAL, PROC_W_SECOND, 25 * GEV, 60000, 40 * GEV, 25 * GEV,
              30 * GEV, 0);
    run_phase(60, 1'b0);
    configure(CS_GENERAL, PROC_W_FIRST, 15 * GEV, 50000, 50 * GEV, 20 * GEV, 0,
              20 * GEV);
    run_phase(60, 1'b0);
    configure(CS_GENERAL, PROC_NONE, 10 * GEV, 50000, 30 * GEV, 20 * GEV, 10 * GEV,
              5 * GEV);
    run_phase(50, 1'b0);
    configure(CS_GENERAL, PROC_Z, 524287, 0, 524287, 524287, 524287, 524287);
    run_phase(40, 1'b0);
    configure(CS_GENERAL, PROC_W_SECOND, 0, 131071, 0, 0, 0, 0);
    run_phase(40, 1'b0);
    configure(CS_GENERAL, PROC_W_FIRST, 1, 65535, 1, 1, 1, 1);
    run_phase(40, 1'b0);
    configure(CS_PRESET_A, PROC_Z, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(70, 1'b0);
    configure(CS_PRESET_B, PROC_Z, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(60, 1'b0);
    configure(CS_PRESET_C, PROC_Z, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(60, 1'b0);
    configure(CS_PRESET_D, PROC_Z, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(60, 1'b0);
    configure(CS_PRESET_A, PROC_W_SECOND, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(50, 1'b0);
    configure(CS_PRESET_B, PROC_W_FIRST, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(50, 1'b0);
    configure(CS_PRESET_C, PROC_W_SECOND, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(60, 1'b0);
    configure(CS_PRESET_C, PROC_NONE, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(40, 1'b0);
    configure(CS_PRESET_D, PROC_W_FIRST, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(40, 1'b0);
    configure(3'd6, PROC_Z, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(30, 1'b0);
    configure(3'd7, PROC_W_SECOND, 20 * GEV, 60000, 0, 0, 0, 0);
    run_phase(30, 1'b0);
    configure(CS_NONE, PROC_Z, 0, RAP_RESET, 0, 0, 0, 0);
    run_phase(40, 1'b0);

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/dfcs_pkg.sv
hdl/dfcs_kin.sv
hdl/dfcs_prod.sv
hdl/dfcs_sq.sv
hdl/dfcs_judge.sv
hdl/dilepton_fiducial_cut_selector.sv
sim/dfcs_checker.sv
sim/dilepton_fiducial_cut_selector_tb.sv
